[hdl/lcf_pkg.sv]
// lcf_pkg: shared constants, command and status types for the cholesky factor block
`default_nettype none
package lcf_pkg;

    localparam int MAX_N     = 8;
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int WIDE_BITS = 64;
    localparam int IDX_W     = $clog2(MAX_N);
    localparam int CNT_W     = IDX_W + 1;
    localparam int DEPTH     = MAX_N * MAX_N;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int LOAD_W    = ADDR_W + 1;
    localparam int RES_W     = 2 * WORD_BITS - FRAC_BITS + IDX_W + 1;
    localparam int THR_W     = WORD_BITS - 1;
    localparam int SIZE_W    = 4;
    localparam int IN_TDATA_W  = ((WORD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_W = WORD_BITS + 2 * IDX_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_N = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET   = SIZE_W'(4);
    localparam logic [THR_W-1:0]  THRESH_RESET = THR_W'(1);

    typedef struct packed {
        logic              src_wr;
        logic [ADDR_W-1:0] src_wr_addr;
        logic [ADDR_W-1:0] src_rd_addr;
        logic [ADDR_W-1:0] fac_rd_a;
        logic [ADDR_W-1:0] fac_rd_b;
        logic              acc_load;
        logic              mul_en;
        logic              acc_sub;
        logic              unit_start;
        logic              unit_div;
        logic              fac_wr;
        logic              fac_wr_zero;
        logic [ADDR_W-1:0] fac_wr_addr;
        logic              diag_wr;
        logic              out_load;
        logic              out_zero;
    } t_cmd;

    typedef struct packed {
        logic res_pos;
        logic div_small;
        logic unit_done;
    } t_stat;

endpackage
`default_nettype wire

[hdl/lcf_sqdiv.sv]
// lcf_sqdiv: iterative square root and saturating fixed-point divide, one bit per cycle
`default_nettype none
module lcf_sqdiv (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic                                 i_div,
    input  wire logic signed [lcf_pkg::RES_W-1:0]     i_res,
    input  wire logic signed [lcf_pkg::WORD_BITS-1:0] i_den,
    output logic                                      o_done,
    output logic        [lcf_pkg::WORD_BITS-1:0]      o_value
);
    localparam int WIDE = lcf_pkg::WIDE_BITS;
    localparam int WORD = lcf_pkg::WORD_BITS;
    localparam int FRAC = lcf_pkg::FRAC_BITS;
    localparam int RW   = lcf_pkg::RES_W;
    localparam int STEP_W = $clog2(WIDE);
    localparam logic [WIDE-1:0] WMAX_W = {{(WIDE-WORD+1){1'b0}}, {(WORD-1){1'b1}}};
    localparam logic [WIDE-1:0] WMIN_MAG = WMAX_W + WIDE'(1);
    localparam logic [WORD-1:0] WMAX = {1'b0, {(WORD-1){1'b1}}};
    localparam logic [WORD-1:0] WMIN = {1'b1, {(WORD-1){1'b0}}};

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_div, n_div;
    logic              r_neg, n_neg;
    logic              r_big, n_big;
    logic [WIDE-1:0]   r_acc, n_acc;
    logic [WIDE-1:0]   r_quo, n_quo;
    logic [WIDE-1:0]   r_bit, n_bit;
    logic [WORD:0]     r_rem, n_rem;
    logic [WORD-1:0]   r_den, n_den;

    logic [RW-1:0]   w_mag;
    logic [WORD-1:0] w_dmag;
    logic [WIDE-1:0] w_root_in;
    logic [WIDE-1:0] w_t;
    logic [WORD:0]   w_rem_sh;

    always_comb begin
        w_mag  = i_res[RW-1] ? (~i_res + RW'(1)) : i_res;
        w_dmag = i_den[WORD-1] ? (~i_den + WORD'(1)) : i_den;
        if (|i_res[RW-1:WIDE-FRAC]) begin
            w_root_in = {{(WIDE-FRAC){1'b1}}, {FRAC{1'b0}}};
        end else begin
            w_root_in = {i_res[WIDE-FRAC-1:0], {FRAC{1'b0}}};
        end
        w_t      = r_quo + r_bit;
        w_rem_sh = {r_rem[WORD-1:0], r_acc[WIDE-1]};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_div  = r_div;
        n_neg  = r_neg;
        n_big  = r_big;
        n_acc  = r_acc;
        n_quo  = r_quo;
        n_bit  = r_bit;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_div  = i_div;
            n_quo  = '0;
            n_rem  = '0;
            n_bit  = WIDE'(1) << (WIDE - 2);
            n_den  = w_dmag;
            if (i_div) begin
                n_cnt = STEP_W'(WIDE - 1);
                n_neg = i_res[RW-1] ^ i_den[WORD-1];
                n_big = |w_mag[RW-1:WIDE-1-FRAC];
                n_acc = {w_mag[WIDE-1-FRAC-1:0], {(FRAC+1){1'b0}}} >> 1;
            end else begin
                n_cnt = STEP_W'(WIDE / 2 - 1);
                n_neg = 1'b0;
                n_big = 1'b0;
                n_acc = w_root_in;
            end
        end else if (r_busy) begin
            if (r_div) begin
                // restoring divide step
                n_acc = r_acc << 1;
                if (w_rem_sh >= {1'b0, r_den}) begin
                    n_rem = w_rem_sh - {1'b0, r_den};
                    n_quo = {r_quo[WIDE-2:0], 1'b1};
                end else begin
                    n_rem = w_rem_sh;
                    n_quo = {r_quo[WIDE-2:0], 1'b0};
                end
            end else begin
                // digit-by-digit root step
                if (r_acc >= w_t) begin
                    n_acc = r_acc - w_t;
                    n_quo = (r_quo >> 1) + r_bit;
                end else begin
                    n_quo = r_quo >> 1;
                end
                n_bit = r_bit >> 2;
            end
            n_cnt = r_cnt - STEP_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_div <= n_div;
        r_neg <= n_neg;
        r_big <= n_big;
        r_acc <= n_acc;
        r_quo <= n_quo;
        r_bit <= n_bit;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    // saturate to the signed word range
    always_comb begin
        if (r_neg) begin
            if (r_big || r_quo > WMIN_MAG) begin
                o_value = WMIN;
            end else begin
                o_value = ~r_quo[WORD-1:0] + WORD'(1);
            end
        end else begin
            if (r_big || r_quo > WMAX_W) begin
                o_value = WMAX;
            end else begin
                o_value = r_quo[WORD-1:0];
            end
        end
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

[hdl/lcf_datapath.sv]
// lcf_datapath: source and factor memories, multiply-accumulate, root and divide unit and output data register
`default_nettype none
module lcf_datapath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire lcf_pkg::t_cmd                      i_cmd,
    input  wire logic [lcf_pkg::WORD_BITS-1:0]      i_in_data,
    input  wire logic [lcf_pkg::THR_W-1:0]          i_small_thr,
    output lcf_pkg::t_stat                          o_stat,
    output logic [lcf_pkg::WORD_BITS-1:0]           o_out_data
);
    localparam int WORD = lcf_pkg::WORD_BITS;
    localparam int WIDE = lcf_pkg::WIDE_BITS;
    localparam int RW   = lcf_pkg::RES_W;

    logic [WORD-1:0] src_mem [lcf_pkg::DEPTH];
    logic [WORD-1:0] fac_mem [lcf_pkg::DEPTH];

    logic [WORD-1:0]        r_src_q;
    logic signed [WORD-1:0] r_fa_q, r_fb_q;
    logic signed [WIDE-1:0] r_prod;
    logic signed [RW-1:0]   r_res;
    logic [WORD-1:0]        r_diag;
    logic [WORD-1:0]        r_out;

    logic                   w_done;
    logic [WORD-1:0]        w_unit;
    logic [WORD-1:0]        w_fac_wdata;
    logic signed [WIDE-1:0] w_term;
    logic [WORD-1:0]        w_dmag;

    lcf_sqdiv u_sqdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.unit_start),
        .i_div   (i_cmd.unit_div),
        .i_res   (r_res),
        .i_den   (r_diag),
        .o_done  (w_done),
        .o_value (w_unit)
    );

    assign w_fac_wdata = i_cmd.fac_wr_zero ? '0 : w_unit;
    assign w_term      = r_prod >>> lcf_pkg::FRAC_BITS;
    assign w_dmag      = r_diag[WORD-1] ? (~r_diag + WORD'(1)) : r_diag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.src_wr) begin
            src_mem[i_cmd.src_wr_addr] <= i_in_data;
        end
        r_src_q <= src_mem[i_cmd.src_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fac_wr) begin
            fac_mem[i_cmd.fac_wr_addr] <= w_fac_wdata;
        end
        r_fa_q <= fac_mem[i_cmd.fac_rd_a];
        r_fb_q <= fac_mem[i_cmd.fac_rd_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= r_fa_q * r_fb_q;
        end
        if (i_cmd.acc_load) begin
            r_res <= RW'($signed(r_src_q));
        end else if (i_cmd.acc_sub) begin
            r_res <= r_res - $signed(w_term[RW-1:0]);
        end
        if (i_cmd.diag_wr) begin
            r_diag <= w_fac_wdata;
        end
        if (i_cmd.out_load) begin
            r_out <= i_cmd.out_zero ? '0 : r_fa_q;
        end
    end

    always_comb begin
        o_stat.res_pos   = !r_res[RW-1] && (|r_res);
        o_stat.div_small = (w_dmag == '0) || (w_dmag < {1'b0, i_small_thr});
        o_stat.unit_done = w_done;
    end

    assign o_out_data = r_out;

endmodule
`default_nettype wire

[hdl/lcf_ctrl.sv]
// lcf_ctrl: load counting and sequencing of the column-by-column factorization and output
`default_nettype none
module lcf_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [lcf_pkg::SIZE_W-1:0]    i_size_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [lcf_pkg::IDX_W-1:0]          o_out_row,
    output logic [lcf_pkg::IDX_W-1:0]          o_out_col,
    output logic                               o_out_last,
    output logic                               o_not_pos_def,
    output lcf_pkg::t_cmd                      o_cmd,
    input  wire lcf_pkg::t_stat                i_stat
);
    localparam int IW = lcf_pkg::IDX_W;
    localparam int CW = lcf_pkg::CNT_W;
    localparam int AW = lcf_pkg::ADDR_W;
    localparam int LW = lcf_pkg::LOAD_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRC   = 4'd1;
    localparam logic [3:0] S_ACC0  = 4'd2;
    localparam logic [3:0] S_KRD   = 4'd3;
    localparam logic [3:0] S_KMUL  = 4'd4;
    localparam logic [3:0] S_KACC  = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_UNIT  = 4'd7;
    localparam logic [3:0] S_ORD   = 4'd8;
    localparam logic [3:0] S_OLD   = 4'd9;
    localparam logic [3:0] S_OWAIT = 4'd10;

    logic [3:0]  r_state, n_state;
    logic [LW-1:0] r_load, n_load;
    logic [CW-1:0] r_n, n_n;
    logic [IW-1:0] r_j, n_j, r_i, n_i, r_k, n_k;
    logic [IW-1:0] r_row, n_row, r_col, n_col;
    logic        r_err, n_err;
    logic        r_ovalid, n_ovalid;

    logic [CW-1:0] w_n_eff;
    logic [LW-1:0] w_nn;
    logic [AW-1:0] w_ld_idx;
    logic [LW-1:0] w_ld_next;
    logic          w_last_i, w_last_j, w_diag, w_advance;
    logic          w_last_row, w_last_col;

    always_comb begin
        if (i_size_n == '0) begin
            w_n_eff = CW'(1);
        end else if (i_size_n > lcf_pkg::SIZE_W'(lcf_pkg::MAX_N)) begin
            w_n_eff = CW'(lcf_pkg::MAX_N);
        end else begin
            w_n_eff = CW'(i_size_n);
        end
        w_nn      = LW'(w_n_eff * w_n_eff);
        w_ld_idx  = (r_load >= LW'(lcf_pkg::DEPTH)) ? '0 : r_load[AW-1:0];
        w_ld_next = LW'(w_ld_idx) + LW'(1);
        w_last_i  = (CW'(r_i) + CW'(1)) == r_n;
        w_last_j  = (CW'(r_j) + CW'(1)) == r_n;
        w_diag    = r_i == r_j;
        w_last_row = (CW'(r_row) + CW'(1)) == r_n;
        w_last_col = (CW'(r_col) + CW'(1)) == r_n;
    end

    always_comb begin
        n_state  = r_state;
        n_load   = r_load;
        n_n      = r_n;
        n_j      = r_j;
        n_i      = r_i;
        n_k      = r_k;
        n_row    = r_row;
        n_col    = r_col;
        n_err    = r_err;
        n_ovalid = r_ovalid;
        w_advance = 1'b0;

        o_cmd             = '0;
        o_cmd.src_wr_addr = w_ld_idx;
        o_cmd.src_rd_addr = AW'(r_j * r_n) + AW'(r_i);
        o_cmd.fac_rd_a    = AW'(r_i * lcf_pkg::MAX_N) + AW'(r_k);
        o_cmd.fac_rd_b    = AW'(r_j * lcf_pkg::MAX_N) + AW'(r_k);
        o_cmd.fac_wr_addr = AW'(r_i * lcf_pkg::MAX_N) + AW'(r_j);
        o_cmd.unit_div    = !w_diag;
        o_cmd.diag_wr     = w_diag;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.src_wr = 1'b1;
                    if (w_ld_next >= w_nn) begin
                        n_load  = '0;
                        n_n     = w_n_eff;
                        n_j     = '0;
                        n_i     = '0;
                        n_err   = 1'b0;
                        n_state = S_SRC;
                    end else begin
                        n_load = w_ld_next;
                    end
                end
            end
            S_SRC: begin
                n_state = S_ACC0;
            end
            S_ACC0: begin
                o_cmd.acc_load = 1'b1;
                n_k = '0;
                n_state = (r_j == '0) ? S_FIN : S_KRD;
            end
            S_KRD: begin
                n_state = S_KMUL;
            end
            S_KMUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_KACC;
            end
            S_KACC: begin
                o_cmd.acc_sub = 1'b1;
                n_k = r_k + IW'(1);
                n_state = ((r_k + IW'(1)) == r_j) ? S_FIN : S_KRD;
            end
            S_FIN: begin
                if (w_diag && !i_stat.res_pos) begin
                    o_cmd.fac_wr      = 1'b1;
                    o_cmd.fac_wr_zero = 1'b1;
                    n_err     = 1'b1;
                    w_advance = 1'b1;
                end else if (!w_diag && i_stat.div_small) begin
                    o_cmd.fac_wr      = 1'b1;
                    o_cmd.fac_wr_zero = 1'b1;
                    w_advance = 1'b1;
                end else begin
                    o_cmd.unit_start = 1'b1;
                    n_state = S_UNIT;
                end
            end
            S_UNIT: begin
                if (i_stat.unit_done) begin
                    o_cmd.fac_wr = 1'b1;
                    w_advance = 1'b1;
                end
            end
            S_ORD: begin
                o_cmd.fac_rd_a = AW'(r_row * lcf_pkg::MAX_N) + AW'(r_col);
                n_state = S_OLD;
            end
            S_OLD: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_zero = r_col > r_row;
                n_ovalid = 1'b1;
                n_state  = S_OWAIT;
            end
            S_OWAIT: begin
                if (i_out_ready) begin
                    n_ovalid = 1'b0;
                    if (w_last_col) begin
                        n_col = '0;
                        n_row = r_row + IW'(1);
                        n_state = w_last_row ? S_IDLE : S_ORD;
                    end else begin
                        n_col = r_col + IW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // next element of the column sweep, or on to output
        if (w_advance) begin
            if (!w_last_i) begin
                n_i = r_i + IW'(1);
                n_state = S_SRC;
            end else if (!w_last_j) begin
                n_j = r_j + IW'(1);
                n_i = r_j + IW'(1);
                n_state = S_SRC;
            end else begin
                n_row = '0;
                n_col = '0;
                n_state = S_ORD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_load   <= '0;
            r_err    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_load   <= n_load;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
        r_n   <= n_n;
        r_j   <= n_j;
        r_i   <= n_i;
        r_k   <= n_k;
        r_row <= n_row;
        r_col <= n_col;
    end

    assign o_in_ready    = r_state == S_IDLE;
    assign o_out_valid   = r_ovalid;
    assign o_out_row     = r_row;
    assign o_out_col     = r_col;
    assign o_out_last    = w_last_row && w_last_col;
    assign o_not_pos_def = w_last_row && w_last_col && r_err;

endmodule
`default_nettype wire

[hdl/lower_cholesky_factor.sv]
// lower_cholesky_factor: top level, configuration registers, stream ports and checks
// load: one beat per cycle, n*n beats; the last beat starts the factorization
// factor: per element a source read and an accumulator load, then a read, a multiply and a subtract
//   per inner product term, then a root or a divide in the bit-serial unit, or a zero write when zeroed
// output: per beat a factor read, an output register load and a wait for ready, n*n beats row-major
// input is not taken from the last load beat until the last output beat is taken
// synchronous active-low reset: order 4, threshold 1, load count 0, no beat pending
`default_nettype none
module lower_cholesky_factor (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // slave stream: tdata = matrix_element[31:0]
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    input  wire logic [lcf_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // master stream: tdata = factor_element[31:0], out_row[34:32], out_col[37:35], zeros
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    output logic [lcf_pkg::OUT_TDATA_W-1:0]           o_m_tdata,
    output logic                                      o_m_tlast,
    // tuser = not_pos_def
    output logic                                      o_m_tuser,
    // configuration write channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [lcf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [lcf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    // configuration registers
    logic [lcf_pkg::SIZE_W-1:0] r_size_n;
    logic [lcf_pkg::THR_W-1:0]  r_small_thr;

    lcf_pkg::t_cmd  w_cmd;
    lcf_pkg::t_stat w_stat;
    logic [lcf_pkg::WORD_BITS-1:0] w_out_data;
    logic [lcf_pkg::IDX_W-1:0]     w_row, w_col;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_n    <= lcf_pkg::SIZE_RESET;
            r_small_thr <= lcf_pkg::THRESH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lcf_pkg::REG_SIZE_N: r_size_n    <= i_cfg_data[lcf_pkg::SIZE_W-1:0];
                lcf_pkg::REG_THRESH: r_small_thr <= i_cfg_data[lcf_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer: load count, column sweep, output walk
    lcf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_size_n      (r_size_n),
        .i_in_valid    (i_s_tvalid),
        .o_in_ready    (o_s_tready),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_out_row     (w_row),
        .o_out_col     (w_col),
        .o_out_last    (o_m_tlast),
        .o_not_pos_def (o_m_tuser),
        .o_cmd         (w_cmd),
        .i_stat        (w_stat)
    );

    // memories, multiply-accumulate, root and divide unit
    lcf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_s_tdata[lcf_pkg::WORD_BITS-1:0]),
        .i_small_thr (r_small_thr),
        .o_stat      (w_stat),
        .o_out_data  (w_out_data)
    );

    assign o_m_tdata = {{(lcf_pkg::OUT_TDATA_W - lcf_pkg::OUT_FIELD_W){1'b0}},
                        w_col, w_row, w_out_data};

`ifndef SYNTHESIS
    // no load beat taken while a result beat is offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input taken while output pending");

    // after the final beat the block returns to loading
    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> o_s_tready)
        else $error("not ready to load after final beat");

    // error flag only on the final beat
    a_flag_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("not_pos_def away from last beat");

    // upper triangle is zero
    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_col > w_row)) |-> (w_out_data == '0))
        else $error("nonzero upper element");
`endif

endmodule
`default_nettype wire

[test/lower_cholesky_factor_tb.sv]
// lower_cholesky_factor_tb: stream testbench with a bit-exact factor predictor and scoreboard
`default_nettype none
module lower_cholesky_factor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef struct {
        logic [31:0] element;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        last;
        logic        npd;
    } t_factor_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic [lcf_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [lcf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lcf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    wire logic s_tready, m_tvalid, m_tlast, m_tuser, cfg_ready;
    wire logic [lcf_pkg::OUT_TDATA_W-1:0] m_tdata;

    lower_cholesky_factor uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .o_m_tlast(m_tlast), .o_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // matrix elements waiting to go out, and factor beats still to come back
    logic [31:0]  elem_q[$];
    t_factor_beat factor_q[$];

    // predictor copy of the block: registers, stores, load position
    logic [3:0]  pred_size = 4'd4;
    logic [30:0] pred_thresh = 31'd1;
    longint      src_mem[lcf_pkg::DEPTH];
    longint      fac_mem[lcf_pkg::DEPTH];
    int          load_pos = 0;

    int  n_errors = 0;
    int  n_elems = 0;
    int  n_results = 0;
    int  n_matrices = 0;
    int  n_npd = 0;
    bit  no_idle = 0;

    // mostly short gaps, now and then a long one; none while a burst stretch runs
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint clip_word(longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    // quotient (num << frac) / den, truncated, saturated to a word
    function automatic longint clip_divide(longint num, longint den);
        longint unsigned un, ud, q;
        bit neg;
        un = (num < 0) ? longint'(-num) : num;
        ud = (den < 0) ? longint'(-den) : den;
        neg = (num < 0) != (den < 0);
        if (un >= (64'd1 << (63 - lcf_pkg::FRAC_BITS))) q = '1;
        else q = (un << lcf_pkg::FRAC_BITS) / ud;
        if (!neg) return (q > longint'(WORD_MAX)) ? WORD_MAX : longint'(q);
        if (q > longint'(WORD_MAX) + 1) return WORD_MIN;
        return -longint'(q);
    endfunction

    // one source element in; on the last one, factor and queue every output beat
    task automatic take_element(input logic [31:0] v);
        int n, nn, i, j, k;
        longint res, d, ad;
        longint unsigned ur;
        bit npd;
        t_factor_beat b;
        n = (pred_size == 0) ? 1 : (pred_size > lcf_pkg::MAX_N) ? lcf_pkg::MAX_N
                                                                 : int'(pred_size);
        nn = n * n;
        if (load_pos >= lcf_pkg::DEPTH) load_pos = 0;
        src_mem[load_pos] = longint'(signed'(v));
        load_pos++;
        n_elems++;
        if (load_pos < nn) return;
        load_pos = 0;
        npd = 0;
        foreach (fac_mem[a]) fac_mem[a] = 0;
        for (j = 0; j < n; j++) begin
            for (i = j; i < n; i++) begin
                res = src_mem[j * n + i];
                for (k = 0; k < j; k++)
                    res -= (fac_mem[i * n + k] * fac_mem[j * n + k]) >>> lcf_pkg::FRAC_BITS;
                if (i == j) begin
                    if (res <= 0) begin
                        fac_mem[i * n + j] = 0;
                        npd = 1;
                    end else begin
                        ur = res;
                        if (ur > (64'hFFFF_FFFF_FFFF_FFFF >> lcf_pkg::FRAC_BITS))
                            ur = 64'hFFFF_FFFF_FFFF_FFFF >> lcf_pkg::FRAC_BITS;
                        fac_mem[i * n + j] =
                            clip_word(longint'(int_sqrt(ur << lcf_pkg::FRAC_BITS)));
                    end
                end else begin
                    d = fac_mem[j * n + j];
                    ad = (d < 0) ? -d : d;
                    if (ad == 0 || ad < longint'(pred_thresh)) fac_mem[i * n + j] = 0;
                    else fac_mem[i * n + j] = clip_divide(res, d);
                end
            end
        end
        for (i = 0; i < nn; i++) begin
            b.element = fac_mem[(i / n) * n + (i % n)][31:0];
            b.row = 3'(i / n);
            b.col = 3'(i % n);
            b.last = (i == nn - 1);
            b.npd = b.last && npd;
            factor_q.push_back(b);
        end
        n_matrices++;
        if (npd) n_npd++;
    endtask

    // source driver: next beat loaded when the slot is free and no gap is running
    int s_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) take_element(s_tdata[31:0]);
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (elem_q.size() > 0) begin
                    s_tdata <= elem_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_gap <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // register writes land in the predictor on the handshake
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_valid && cfg_ready) begin
            if (cfg_index == lcf_pkg::REG_SIZE_N) pred_size <= cfg_data[3:0];
            else if (cfg_index == lcf_pkg::REG_THRESH) pred_thresh <= cfg_data[30:0];
        end
    end

    // result monitor and random backpressure
    int m_gap = 0;
    always @(posedge i_clk) begin
        t_factor_beat e;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (factor_q.size() == 0) begin
                    $error("factor beat with nothing expected: tdata %h", m_tdata);
                    n_errors++;
                end else begin
                    e = factor_q.pop_front();
                    if (m_tdata[31:0] !== e.element) begin
                        $error("factor_element expected %h got %h", e.element, m_tdata[31:0]);
                        n_errors++;
                    end
                    if (m_tdata[34:32] !== e.row) begin
                        $error("out_row expected %0d got %0d", e.row, m_tdata[34:32]);
                        n_errors++;
                    end
                    if (m_tdata[37:35] !== e.col) begin
                        $error("out_col expected %0d got %0d", e.col, m_tdata[37:35]);
                        n_errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("out_last expected %b got %b", e.last, m_tlast);
                        n_errors++;
                    end
                    if (m_tuser !== e.npd) begin
                        $error("not_pos_def expected %b got %b", e.npd, m_tuser);
                        n_errors++;
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) m_gap <= pick_gap();
            end
        end
    end

    task automatic write_reg(input logic [lcf_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // block idle: nothing queued, nothing in flight, a short settle after the last beat
    task automatic drain();
        @(posedge i_clk);
        while (elem_q.size() != 0 || s_tvalid || factor_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // one matrix of order n; kind 0 well formed, 1 raw noise, 2 broken diagonal
    task automatic push_matrix(input int n, input int kind);
        logic [31:0] a[8][8];
        longint rowsum;
        int r, c, bad;
        bad = $urandom_range(0, n - 1);
        for (r = 0; r < n; r++)
            for (c = r + 1; c < n; c++) begin
                a[r][c] = $urandom_range(0, 3) == 0 ? $urandom() :
                          32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
                if (kind == 0 && a[r][c][31] != a[r][c][30]) a[r][c] = a[r][c] >>> 12;
                // strictly lower part is ignored: mirror or scribble
                a[c][r] = $urandom_range(0, 1) ? a[r][c] : $urandom();
            end
        for (r = 0; r < n; r++) begin
            rowsum = 0;
            for (c = 0; c < n; c++)
                if (c != r) rowsum += (signed'(a[r][c]) < 0) ? -longint'(signed'(a[r][c]))
                                                             : longint'(signed'(a[r][c]));
            a[r][r] = 32'(rowsum + $urandom_range(1, 1 << 20));
            if (a[r][r][31]) a[r][r] = 32'h7FFF_FFFF;
            if (kind == 1) a[r][r] = $urandom();
            if (kind == 2 && r == bad)
                a[r][r] = $urandom_range(0, 1) ? 32'h0 : $urandom() | 32'h8000_0000;
        end
        for (r = 0; r < n; r++)
            for (c = 0; c < n; c++)
                if (kind == 1) elem_q.push_back($urandom());
                else elem_q.push_back(a[r][c]);
    endtask

    function automatic int eff_order(input logic [3:0] s);
        return (s == 0) ? 1 : (s > lcf_pkg::MAX_N) ? lcf_pkg::MAX_N : int'(s);
    endfunction

    initial begin
        int sent, k, m, r;
        logic [3:0] sz;
        logic [31:0] th;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: order one with zero, largest and most negative elements
        write_reg(lcf_pkg::REG_SIZE_N, 32'd1);
        elem_q.push_back(32'h0000_0000);
        elem_q.push_back(32'h7FFF_FFFF);
        elem_q.push_back(32'h8000_0000);
        elem_q.push_back(32'h0001_0000);
        drain();
        // order two: huge off-diagonal saturates the divide, and a negative residual
        write_reg(lcf_pkg::REG_SIZE_N, 32'd2);
        elem_q.push_back(32'h0000_0001);
        elem_q.push_back(32'h7FFF_FFFF);
        elem_q.push_back(32'h1234_5678);
        elem_q.push_back(32'h0000_0000);
        elem_q.push_back(32'h0004_0000);
        elem_q.push_back(32'h8000_0000);
        elem_q.push_back(32'hFFFF_FFFF);
        elem_q.push_back(32'h7FFF_FFFF);
        drain();
        // threshold at zero, then at the top so every divisor below the largest word counts as small
        write_reg(lcf_pkg::REG_THRESH, 32'd0);
        elem_q.push_back(32'h0000_0000);
        elem_q.push_back(32'h0003_0000);
        elem_q.push_back(32'h0003_0000);
        elem_q.push_back(32'h0010_0000);
        drain();
        write_reg(lcf_pkg::REG_THRESH, 32'h7FFF_FFFF);
        elem_q.push_back(32'h0004_0000);
        elem_q.push_back(32'h0001_0000);
        elem_q.push_back(32'h0001_0000);
        elem_q.push_back(32'h0004_0000);
        drain();
        // order zero acts as one, order fifteen as the maximum
        write_reg(lcf_pkg::REG_SIZE_N, 32'd0);
        write_reg(lcf_pkg::REG_THRESH, 32'd1);
        elem_q.push_back(32'h0009_0000);
        drain();
        write_reg(lcf_pkg::REG_SIZE_N, 32'd15);
        push_matrix(lcf_pkg::MAX_N, 0);
        drain();

        // random phases, mostly small orders, up to the overall element budget
        sent = n_elems;
        while (sent < 230) begin
            r = $urandom_range(0, 19);
            sz = (r < 16) ? 4'($urandom_range(1, 4)) : (r < 18) ? 4'($urandom_range(5, 8)) :
                 (r == 18) ? 4'd0 : 4'($urandom_range(9, 15));
            r = $urandom_range(0, 9);
            th = (r < 3) ? 32'd1 : (r < 5) ? $urandom_range(0, 1 << 16) :
                 (r < 7) ? $urandom_range(1 << 16, 1 << 22) : (r == 7) ? 32'd0 :
                 (r == 8) ? 32'h7FFF_FFFF : ($urandom() >> 1);
            write_reg(lcf_pkg::REG_SIZE_N, {28'd0, sz});
            write_reg(lcf_pkg::REG_THRESH, th);
            no_idle = ($urandom_range(0, 4) == 0);
            m = $urandom_range(1, 3);
            for (k = 0; k < m && sent < 230; k++) begin
                r = $urandom_range(0, 9);
                push_matrix(eff_order(sz), (r < 7) ? 0 : (r < 9) ? 2 : 1);
                sent += eff_order(sz) * eff_order(sz);
            end
            drain();
        end
        no_idle = 0;

        repeat (50) @(posedge i_clk);
        if (factor_q.size() != 0) begin
            $error("%0d factor beats never arrived", factor_q.size());
            n_errors++;
        end
        $display("covered %0d matrices (%0d not positive definite),", n_matrices, n_npd);
        $display("  %0d elements in, %0d beats out", n_elems, n_results);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
